// ===== hdl/pfc_pkg.sv =====
// Shared types, constants and letter/position helpers for the Playfair cipher core.
`default_nettype none
package pfc_pkg;

	// Command codes
	localparam logic [1:0] CMD_KEY     = 2'd0;
	localparam logic [1:0] CMD_FINISH  = 2'd1;
	localparam logic [1:0] CMD_ENCRYPT = 2'd2;
	localparam logic [1:0] CMD_DECRYPT = 2'd3;

	// Letter and square constants
	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;
	localparam logic [4:0] LETTER_Z = 5'd25;
	localparam int         SIDE     = 5;
	localparam int         CELLS    = SIDE * SIDE;
	localparam int         LETTERS  = 26;

	// Status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_READY = 1'b1;

	typedef struct packed {
		logic [1:0] command;
		logic [4:0] first_letter;
		logic [4:0] second_letter;
	} pfc_in_t;

	typedef struct packed {
		logic [4:0] out_first;
		logic [4:0] out_second;
		logic       status;
	} pfc_out_t;

	// Requests from the sequencer to the key store
	typedef struct packed {
		logic       place_en;
		logic [4:0] place_letter;
		logic       pos_rd_en;
		logic [4:0] pos_addr_a;
		logic [4:0] pos_addr_b;
		logic       sq_rd_en;
		logic [4:0] sq_addr_a;
		logic [4:0] sq_addr_b;
	} pfc_ks_ctrl_t;

	// Registered read data from the key store
	typedef struct packed {
		logic [4:0] pos_a;
		logic [4:0] pos_b;
		logic [4:0] sq_a;
		logic [4:0] sq_b;
	} pfc_ks_data_t;

	// Clamp out-of-range letters to z and fold j to i
	function automatic logic [4:0] fold_letter(input logic [4:0] v);
		logic [4:0] t;
		t = (v > LETTER_Z) ? LETTER_Z : v;
		return (t == LETTER_J) ? LETTER_I : t;
	endfunction

	// Row of a square position (0..24)
	function automatic logic [2:0] pos_row(input logic [4:0] p);
		if (p >= 5'd20) return 3'd4;
		if (p >= 5'd15) return 3'd3;
		if (p >= 5'd10) return 3'd2;
		if (p >= 5'd5)  return 3'd1;
		return 3'd0;
	endfunction

	// Column of a square position: p - 5*row
	function automatic logic [2:0] pos_col(input logic [4:0] p);
		logic [2:0] r;
		logic [4:0] base;
		r    = pos_row(p);
		base = {r, 2'b00} + {2'b00, r};
		return 3'(p - base);
	endfunction

	// Square position of a row and column: 5*row + col
	function automatic logic [4:0] cell_addr(input logic [2:0] r, input logic [2:0] c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

	// Cyclic step by one inside 0..4, forward or backward
	function automatic logic [2:0] wrap_step(input logic [2:0] x, input logic fwd);
		if (fwd) return (x == 3'd4) ? 3'd0 : 3'(x + 3'd1);
		return (x == 3'd0) ? 3'd4 : 3'(x - 3'd1);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/playfair_digraph_cipher_core.sv =====
// Top level: sequencer, pair rule logic and result register of the Playfair cipher core.
// Key letter: accepted with no result; key items can follow back to back.
// Finish key: accept, then one placement slot per letter a..z in ST_FILL.
// Pair with key ready: result register loaded after position read, rule and square read,
//   and square data capture in turn; no new item is taken until ST_EMIT hands the result on.
// Pair before finish: result loaded on accept, status not ready. arst_n clears control state.
`default_nettype none
module playfair_digraph_cipher_core import pfc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire pfc_in_t  req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output pfc_out_t      rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]   state_q;
	logic         key_ready_q;
	logic [4:0]   fill_v_q;
	logic         enc_q;
	pfc_out_t     res_q;
	pfc_out_t     rsp_q;
	logic         rsp_valid_q;
	pfc_ks_ctrl_t ctrl;
	pfc_ks_data_t data;
	logic         accept;
	logic         out_free;
	logic [2:0]   ra, ca, rb, cb;
	logic [2:0]   oa_r, oa_c, ob_r, ob_c;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Pair rule: same row, same column, else rectangle corners
	always_comb begin
		ra = pos_row(data.pos_a);
		ca = pos_col(data.pos_a);
		rb = pos_row(data.pos_b);
		cb = pos_col(data.pos_b);
		if (ra == rb) begin
			oa_r = ra;                   oa_c = wrap_step(ca, enc_q);
			ob_r = rb;                   ob_c = wrap_step(cb, enc_q);
		end else if (ca == cb) begin
			oa_r = wrap_step(ra, enc_q); oa_c = ca;
			ob_r = wrap_step(rb, enc_q); ob_c = cb;
		end else begin
			oa_r = ra;                   oa_c = cb;
			ob_r = rb;                   ob_c = ca;
		end
	end

	// Key store requests
	always_comb begin
		ctrl = '0;
		ctrl.pos_addr_a = fold_letter(req.first_letter);
		ctrl.pos_addr_b = fold_letter(req.second_letter);
		ctrl.sq_addr_a  = cell_addr(oa_r, oa_c);
		ctrl.sq_addr_b  = cell_addr(ob_r, ob_c);
		case (state_q)
			ST_IDLE: begin
				if (accept && req.command == CMD_KEY && !key_ready_q
					&& req.first_letter <= LETTER_Z) begin
					ctrl.place_en     = 1'b1;
					ctrl.place_letter = fold_letter(req.first_letter);
				end
				ctrl.pos_rd_en = accept && key_ready_q
					&& (req.command == CMD_ENCRYPT || req.command == CMD_DECRYPT);
			end
			ST_FILL: begin
				ctrl.place_en     = (fill_v_q != LETTER_J);
				ctrl.place_letter = fill_v_q;
			end
			ST_CALC: ctrl.sq_rd_en = 1'b1;
			default: ;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_ready_q <= 1'b0;
			fill_v_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Output valid: set on load, cleared once taken
			if (state_q == ST_EMIT && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.command == CMD_FINISH) begin
							if (!key_ready_q) begin
								fill_v_q <= '0;
								state_q  <= ST_FILL;
							end
						end else if (req.command != CMD_KEY) begin
							state_q <= key_ready_q ? ST_CALC : ST_EMIT;
						end
					end
				end
				ST_FILL: begin
					if (fill_v_q == LETTER_Z) begin
						key_ready_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						fill_v_q <= fill_v_q + 5'd1;
					end
				end
				ST_CALC: state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pending result and output register
	always_ff @(posedge clk) begin
		if (accept)
			enc_q <= (req.command == CMD_ENCRYPT);
		if (accept && !key_ready_q) begin
			res_q.out_first  <= '0;
			res_q.out_second <= '0;
			res_q.status     <= STATUS_NOT_READY;
		end else if (state_q == ST_SQ) begin
			res_q.out_first  <= data.sq_a;
			res_q.out_second <= data.sq_b;
			res_q.status     <= STATUS_OK;
		end
		if (state_q == ST_EMIT && out_free)
			rsp_q <= res_q;
	end

	pfc_keystore u_keystore (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.data   (data)
	);

	a_key_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		key_ready_q |=> key_ready_q)
		else $error("key ready dropped");

	a_fill_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> !key_ready_q)
		else $error("filling a finished square");

	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == STATUS_NOT_READY)
		|-> (rsp_q.out_first == 5'd0 && rsp_q.out_second == 5'd0))
		else $error("not-ready result carries letters");

	a_no_j_out: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == STATUS_OK)
		|-> (rsp_q.out_first != LETTER_J && rsp_q.out_second != LETTER_J))
		else $error("result holds letter j");

endmodule
`default_nettype wire

// ===== hdl/pfc_keystore.sv =====
// Key square store: square and position memories, used flags and the shared placement unit.
`default_nettype none
module pfc_keystore import pfc_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire pfc_ks_ctrl_t ctrl,
	output pfc_ks_data_t      data
);

	logic [4:0] square_mem [CELLS];
	logic [4:0] position_mem [LETTERS];
	logic [LETTERS-1:0] used_q;
	logic [4:0] fill_q;
	logic       do_place;

	// Placement unit: a letter goes in only once, and only while cells remain
	assign do_place = ctrl.place_en && !used_q[ctrl.place_letter]
		&& (fill_q < 5'(CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			fill_q <= '0;
		end else if (do_place) begin
			used_q[ctrl.place_letter] <= 1'b1;
			fill_q <= fill_q + 5'd1;
		end
	end

	// Memory writes, no reset
	always_ff @(posedge clk) begin
		if (do_place) begin
			square_mem[fill_q]               <= ctrl.place_letter;
			position_mem[ctrl.place_letter]  <= fill_q;
		end
	end

	// Registered reads, two ports per memory
	always_ff @(posedge clk) begin
		if (ctrl.pos_rd_en) begin
			data.pos_a <= position_mem[ctrl.pos_addr_a];
			data.pos_b <= position_mem[ctrl.pos_addr_b];
		end
		if (ctrl.sq_rd_en) begin
			data.sq_a <= square_mem[ctrl.sq_addr_a];
			data.sq_b <= square_mem[ctrl.sq_addr_b];
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 5'(CELLS))
		else $error("fill count beyond square size");

	a_place_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_place |=> fill_q == $past(fill_q) + 5'd1)
		else $error("placement did not advance fill count");

	a_fill_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 5'($countones(used_q)))
		else $error("fill count differs from used letters");

endmodule
`default_nettype wire

// ===== tb/pfc_cipher_checker.sv =====
// Checker for the Playfair cipher core: predicts each pair result and compares the response items.
`timescale 1ns / 100ps
module pfc_cipher_checker import pfc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	input  wire logic     req_ready,
	input  wire pfc_in_t  req,
	input  wire logic     rsp_valid,
	input  wire logic     rsp_ready,
	input  wire pfc_out_t rsp,
	output int            error_count,
	output int            outstanding
);

	// Shadow key square
	logic [4:0] key_square [CELLS];
	logic [4:0] letter_cell [LETTERS];
	logic       letter_taken [LETTERS];
	int         cells_filled;
	bit         square_done;

	// Cipher results still owed by the core, oldest first
	pfc_out_t   cipher_results_due [$];
	int         fails = 0;

	assign error_count = fails;

	task automatic report(input string msg);
		$display("%0t ns: MISMATCH %s", $time, msg);
		fails++;
	endtask

	// Append a letter to the square unless it is already there or the square is full
	task automatic place_letter(input logic [4:0] v);
		if (!letter_taken[v] && cells_filled < CELLS) begin
			key_square[cells_filled] = v;
			letter_cell[v]           = 5'(cells_filled);
			letter_taken[v]          = 1'b1;
			cells_filled++;
		end
	endtask

	// Clamp to z, then fold j onto i
	function automatic logic [4:0] pair_letter(input logic [4:0] v);
		logic [4:0] t;
		t = (v > LETTER_Z) ? LETTER_Z : v;
		return (t == LETTER_J) ? LETTER_I : t;
	endfunction

	// Encrypt or decrypt one digraph against the shadow square
	function automatic pfc_out_t predict_cipher(input pfc_in_t it);
		pfc_out_t res;
		int       pa, pb, ra, ca, rb, cb, step;
		res.out_first  = '0;
		res.out_second = '0;
		res.status     = STATUS_NOT_READY;
		if (!square_done)
			return res;
		pa   = letter_cell[pair_letter(it.first_letter)];
		pb   = letter_cell[pair_letter(it.second_letter)];
		ra   = pa / SIDE;
		ca   = pa % SIDE;
		rb   = pb / SIDE;
		cb   = pb % SIDE;
		step = (it.command == CMD_ENCRYPT) ? 1 : SIDE - 1;
		res.status = STATUS_OK;
		if (ra == rb) begin
			res.out_first  = key_square[ra * SIDE + (ca + step) % SIDE];
			res.out_second = key_square[rb * SIDE + (cb + step) % SIDE];
		end else if (ca == cb) begin
			res.out_first  = key_square[((ra + step) % SIDE) * SIDE + ca];
			res.out_second = key_square[((rb + step) % SIDE) * SIDE + cb];
		end else begin
			res.out_first  = key_square[ra * SIDE + cb];
			res.out_second = key_square[rb * SIDE + ca];
		end
		return res;
	endfunction

	// Update the shadow state for one accepted request item
	task automatic apply_request(input pfc_in_t it);
		int v;
		case (it.command)
			CMD_KEY: begin
				if (!square_done && it.first_letter <= LETTER_Z)
					place_letter((it.first_letter == LETTER_J) ? LETTER_I : it.first_letter);
			end
			CMD_FINISH: begin
				if (!square_done) begin
					for (v = 0; v < LETTERS; v++)
						if (v != LETTER_J)
							place_letter(5'(v));
					square_done = 1'b1;
				end
			end
			default: cipher_results_due.push_back(predict_cipher(it));
		endcase
	endtask

	// Watch both channels; responses are checked before the new request is predicted
	always @(posedge clk or negedge arst_n) begin
		pfc_out_t want;
		int       k;
		if (!arst_n) begin
			for (k = 0; k < CELLS; k++)
				key_square[k] = '0;
			for (k = 0; k < LETTERS; k++) begin
				letter_cell[k]  = '0;
				letter_taken[k] = 1'b0;
			end
			cells_filled = 0;
			square_done  = 1'b0;
			cipher_results_due.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (cipher_results_due.size() == 0) begin
					report($sformatf("unexpected result %0d/%0d status %0d",
						rsp.out_first, rsp.out_second, rsp.status));
				end else begin
					want = cipher_results_due.pop_front();
					if (rsp.out_first !== want.out_first)
						report($sformatf("out_first got %0d want %0d",
							rsp.out_first, want.out_first));
					if (rsp.out_second !== want.out_second)
						report($sformatf("out_second got %0d want %0d",
							rsp.out_second, want.out_second));
					if (rsp.status !== want.status)
						report($sformatf("status got %0d want %0d",
							rsp.status, want.status));
				end
			end
			if (req_valid && req_ready)
				apply_request(req);
			outstanding <= cipher_results_due.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the Playfair cipher core: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 100ps
module tb;
	import pfc_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_PAIRS  = 560;
	localparam int DRAIN_CYCLES = 40;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	pfc_in_t  req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	pfc_out_t rsp;

	int       error_count;
	int       outstanding;
	int       tx_idle   = 0;
	int       rx_idle   = 0;
	int       cycles    = 0;

	playfair_digraph_cipher_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	pfc_cipher_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Response side: random stalls, plus one long hold-off so the core backs up
	initial begin
		int served;
		int hold_left;
		bit held;
		served    = 0;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				served++;
			if (!held && served == 300) begin
				held      = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= rx_idle);
			end
		end
	end

	// Offer one item after a random gap and wait for it to be taken
	task automatic send_item(input logic [1:0] cmd, input logic [4:0] a, input logic [4:0] b);
		pfc_in_t it;
		it.command       = cmd;
		it.first_letter  = a;
		it.second_letter = b;
		while ($urandom_range(0, 99) < tx_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	// Mostly in-range letters, sometimes the out-of-range codes too
	function automatic logic [4:0] any_letter();
		if ($urandom_range(0, 7) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, LETTERS - 1));
	endfunction

	task automatic random_pairs(input int count);
		int done_pairs;
		int pick;
		done_pairs = 0;
		while (done_pairs < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// ignored once the square is complete
				send_item(CMD_KEY, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			end else if (pick < 6) begin
				send_item(CMD_FINISH, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
			end else begin
				send_item($urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT,
					any_letter(), any_letter());
				done_pairs++;
			end
		end
	endtask

	// Main stimulus
	initial begin
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 18;
		rx_idle <= 79;

		// pairs before the square exists
		send_item(CMD_ENCRYPT, 5'd0, 5'd31);
		send_item(CMD_DECRYPT, LETTER_Z, LETTER_J);

		// key stream: j folds to i, duplicate, out-of-range letters dropped
		send_item(CMD_KEY, LETTER_J, 5'($urandom_range(0, 31)));
		send_item(CMD_KEY, LETTER_I, 5'($urandom_range(0, 31)));
		send_item(CMD_KEY, 5'd31, 5'($urandom_range(0, 31)));
		send_item(CMD_KEY, 5'd26, 5'($urandom_range(0, 31)));
		send_item(CMD_KEY, LETTER_Z, 5'($urandom_range(0, 31)));
		send_item(CMD_KEY, 5'd0, 5'($urandom_range(0, 31)));
		for (k = 0; k < 6; k++)
			send_item(CMD_KEY, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
		send_item(CMD_FINISH, 5'd0, 5'd0);

		// late key letter and repeated finish change nothing
		send_item(CMD_KEY, 5'd3, 5'd31);
		send_item(CMD_FINISH, 5'd31, 5'd31);

		// identical letters, j, clamped letters, extremes
		send_item(CMD_ENCRYPT, LETTER_I, LETTER_J);
		send_item(CMD_DECRYPT, LETTER_J, LETTER_J);
		send_item(CMD_ENCRYPT, 5'd31, 5'd26);
		send_item(CMD_ENCRYPT, 5'd0, LETTER_Z);
		send_item(CMD_DECRYPT, 5'd0, LETTER_Z);
		send_item(CMD_ENCRYPT, 5'd30, 5'd0);
		send_item(CMD_DECRYPT, any_letter(), any_letter());

		random_pairs(PHASE_PAIRS);

		tx_idle = 79;
		rx_idle <= 18;
		random_pairs(PHASE_PAIRS);

		tx_idle = 0;
		rx_idle <= 0;
		random_pairs(PHASE_PAIRS);

		req_valid <= 1'b0;
		// let the checker count the last accepted item
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
